[rtl/swmp_pkg.sv]
// Shared constants, pixel and column types, and channel-wise maximum helpers
// for the sliding-window max-pool block. No dependencies.
`timescale 1ns / 1ps

package swmp_pkg;

	localparam int WINDOW    = 2;
	localparam int MAX_WIDTH = 1024;
	localparam int LINES     = WINDOW - 1;
	localparam int LSEL_W    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int CFG_W     = 11;
	localparam int CMP_W     = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int IDX_W     = 1;
	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;

	localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] FRAME_SIZE_RST = CFG_W'(1024);

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [WINDOW-1:0] col_t;

	function automatic pix_t chan_max(pix_t a, pix_t b);
		pix_t r;
		r = '0;
		for (int s = 0; s < 3; s++) begin
			r[s*CH_W +: CH_W] = (a[s*CH_W +: CH_W] > b[s*CH_W +: CH_W]) ?
				a[s*CH_W +: CH_W] : b[s*CH_W +: CH_W];
		end
		return r;
	endfunction

	function automatic pix_t col_max(col_t col);
		pix_t m;
		m = '0;
		for (int k = 0; k < WINDOW; k++) begin
			m = chan_max(m, col[k]);
		end
		return m;
	endfunction

endpackage

[rtl/swmp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swmp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/swmp_cell.sv]
// One window column cell: holds a column of pixels, passes it to its neighbor
// on each shift and folds its column into the running window maximum.
// Depends on swmp_pkg.
`timescale 1ns / 1ps

module swmp_cell
	import swmp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift_en,
	input  col_t col_in,
	input  pix_t max_in,
	output col_t col_q,
	output pix_t max_out
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign max_out = chan_max(max_in, col_max(col_q));

endmodule

[rtl/sliding_window_max_pool_rgb_top.sv]
// Top level of the stride-1 sliding-window max pool over RGB pixels.
// Depends on swmp_pkg, swmp_ram and swmp_cell.
`timescale 1ns / 1ps

// Usage
// Pixels arrive on the input channel (in_valid, in_stall, pixel_ch0..2) in
// raster order. An item is taken at a clock edge with in_valid high and
// in_stall low. Frame width and height are written through cfg_wr_en,
// cfg_index and cfg_data while the block is idle; both reset to 1024.
// Each fully covered WINDOW x WINDOW window gives one item on the output
// channel: the per-channel maximum and frame_last, which is set on the
// window that holds the last pixel of the frame. The next pixel starts a
// new frame. Pixels of the first WINDOW-1 rows and columns give no item.
// Throughput is one pixel per clock while no stall holds the pipeline; the
// line store does one read and one write per accepted pixel. A result goes
// through the registered line-store read and stage 1, then the window cells
// and the output register to out_valid; a stall can hold it between them.
// When the receiver stalls with a result waiting, in_stall goes high in the
// same cycle and the whole pipeline holds; with no result waiting, input
// keeps flowing. Reset clears the position counters, the window cells and
// all valid flags. The line store has no clearing pass: every entry is
// written one row before it is read.

module sliding_window_max_pool_rgb_top
	import swmp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             cfg_wr_en,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,

	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CH_W-1:0]  pixel_ch0,
	input  logic [CH_W-1:0]  pixel_ch1,
	input  logic [CH_W-1:0]  pixel_ch2,

	output logic             out_valid,
	input  logic             out_stall,
	output logic [CH_W-1:0]  max_ch0,
	output logic [CH_W-1:0]  max_ch1,
	output logic [CH_W-1:0]  max_ch2,
	output logic             frame_last
);

	// Configuration registers.
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_SIZE_RST;
			frame_height_q <= FRAME_SIZE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the output register is free or being taken.
	logic adv;
	logic in_acc;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	// Raster position of the next pixel and the line buffer it is written to.
	logic [COL_W-1:0]  col_q;
	logic [CFG_W-1:0]  row_q;
	logic [LSEL_W-1:0] line_sel_q;

	logic [CMP_W-1:0]   col_next;
	logic [CMP_W-1:0]   width_eff;
	logic [CFG_W:0]     row_next;
	logic [CFG_W:0]     height_eff;
	logic               last_col;
	logic               last_row;
	logic               emit;
	pix_t               pix_in;

	assign pix_in = {pixel_ch2, pixel_ch1, pixel_ch0};

	// A zero size counts as one; the width is clipped to the line store depth,
	// which shows up as the row ending at the last column of the store.
	assign col_next   = CMP_W'(col_q) + CMP_W'(1);
	assign width_eff  = (frame_width_q == '0) ? CMP_W'(1) : CMP_W'(frame_width_q);
	assign last_col   = (col_next >= width_eff) || (col_next >= CMP_W'(MAX_WIDTH));
	assign row_next   = (CFG_W + 1)'(row_q) + (CFG_W + 1)'(1);
	assign height_eff = (frame_height_q == '0) ? (CFG_W + 1)'(1)
	                                           : (CFG_W + 1)'(frame_height_q);
	assign last_row   = (row_next >= height_eff);
	assign emit       = (row_q >= CFG_W'(WINDOW - 1)) && (col_q >= COL_W'(WINDOW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			line_sel_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q      <= '0;
					line_sel_q <= '0;
				end else begin
					row_q      <= row_next[CFG_W-1:0];
					line_sel_q <= (line_sel_q == LSEL_W'(LINES - 1)) ? '0
					                                                 : line_sel_q + LSEL_W'(1);
				end
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// Line store: one RAM per stored row, read and written at the current column.
	pix_t line_rd [LINES];

	for (genvar k = 0; k < LINES; k++) begin : g_line
		swmp_ram #(
			.WIDTH(PIX_W),
			.DEPTH(MAX_WIDTH)
		) u_line (
			.clk    (clk),
			.wr_en  (in_acc && (line_sel_q == LSEL_W'(k))),
			.wr_addr(col_q),
			.wr_data(pix_in),
			.rd_en  (in_acc),
			.rd_addr(col_q),
			.rd_data(line_rd[k])
		);
	end

	// Stage 1: the accepted pixel waits here for its line-store read.
	logic valid_s1;
	logic emit_s1;
	logic last_s1;
	pix_t pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pix_in;
			emit_s1 <= emit;
			last_s1 <= last_col && last_row;
		end
	end

	// The new window column: stored rows on top, the current pixel at the bottom.
	col_t new_col;

	always_comb begin
		new_col = '0;
		for (int k = 0; k < LINES; k++) begin
			new_col[k] = line_rd[k];
		end
		new_col[WINDOW-1] = pix_s1;
	end

	// Chain of column cells. The top cell takes the new column; each cell hands
	// its column down on a shift. The maximum runs down the chain, starting
	// from the new column, so cell 0 gives the maximum of the shifted window.
	logic shift_en;
	col_t cell_col [LINES];
	pix_t cell_max [LINES];

	assign shift_en = adv && valid_s1;

	for (genvar i = 0; i < LINES; i++) begin : g_cell
		if (i == LINES - 1) begin : g_top
			swmp_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(shift_en),
				.col_in  (new_col),
				.max_in  (col_max(new_col)),
				.col_q   (cell_col[i]),
				.max_out (cell_max[i])
			);
		end else begin : g_mid
			swmp_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(shift_en),
				.col_in  (cell_col[i+1]),
				.max_in  (cell_max[i+1]),
				.col_q   (cell_col[i]),
				.max_out (cell_max[i])
			);
		end
	end

	// Output register.
	pix_t out_max_q;
	logic frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && emit_s1) begin
			out_max_q    <= cell_max[0];
			frame_last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign max_ch0    = out_max_q[0*CH_W +: CH_W];
	assign max_ch1    = out_max_q[1*CH_W +: CH_W];
	assign max_ch2    = out_max_q[2*CH_W +: CH_W];
	assign frame_last = frame_last_q;

endmodule

[rtl/swmp_checker.sv]
// Port-level checks for the sliding-window max pool, bound to the top level.
// Depends on swmp_pkg and sliding_window_max_pool_rgb_top.
`timescale 1ns / 1ps

module swmp_checker
	import swmp_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input logic            out_valid,
	input logic            out_stall,
	input logic [CH_W-1:0] max_ch0,
	input logic [CH_W-1:0] max_ch1,
	input logic [CH_W-1:0] max_ch2,
	input logic            frame_last
);

	// A waiting result that is stalled stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(max_ch0) && $stable(max_ch1) &&
			$stable(max_ch2) && $stable(frame_last))
		else $error("output payload changed while stalled");

	// Input is held off only while a result is waiting on a stalled receiver.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a stalled result");

	// A new result follows a taken pixel.
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a pixel two cycles earlier");

endmodule

bind sliding_window_max_pool_rgb_top swmp_checker u_swmp_checker (.*);
